### sv/lav_pkg.sv
package lav_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  // arithmetic core width, wider fields use their low bits
  localparam int CORE_W = 32;
  localparam int FRAC = 16;
  // normalized axis component: magnitude up to 1.0, sign
  localparam int AXIS_W = 18;
  // magnitudes are aligned so the largest sits in [2^30, 2^31)
  localparam int NORM_W = 31;
  localparam int QUO_W = 17;
  localparam int ROOT_STEPS = 32;
  localparam int SUM_W = 64;
  // true up axis after the floor shift
  localparam int UY_W = 21;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP = 2'd1;
  localparam logic [1:0] ROW_FWD = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic vld;
    logic degen;
  } lav_ctl_t;

  typedef struct packed {
    logic [2:0][2:0][CORE_W-1:0] ax;  // ax[row][col]
    logic [2:0][CORE_W-1:0] tr;       // saturated translations
    logic degen;
  } lav_rows_t;

endpackage

### sv/lav_norm.sv
module lav_norm #(
  parameter int IN_W = 33,  // above 32
  parameter int SB_W = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  lav_pkg::lav_ctl_t in_ctl,
  input  logic [2:0][IN_W-1:0] in_v,
  input  logic [SB_W-1:0] in_sb,
  output lav_pkg::lav_ctl_t out_ctl,
  output logic [2:0][lav_pkg::AXIS_W-1:0] out_o,
  output logic [SB_W-1:0] out_sb
);
  import lav_pkg::*;

  localparam int SD_W = SB_W + 4;  // {sb, zero, signs}
  localparam int LZ_N = 6;
  localparam int DV_N = QUO_W;
  localparam int REM_W = NORM_W + 2;
  localparam int LEN_W = NORM_W + 1;

  // magnitudes and largest component
  logic [2:0] sg_c;
  logic [2:0][IN_W-1:0] mag_c;
  logic [IN_W-1:0] m_c;

  always_comb begin
    m_c = '0;
    for (int i = 0; i < 3; i++) begin
      sg_c[i] = in_v[i][IN_W-1];
      mag_c[i] = sg_c[i] ? (~in_v[i] + 1'b1) : in_v[i];
      if (mag_c[i] > m_c) m_c = mag_c[i];
    end
  end

  logic [2:0][IN_W-1:0] lz_a_r [LZ_N+1];
  logic [IN_W-1:0] lz_m_r [LZ_N+1];
  logic [SD_W-1:0] lz_sd_r [LZ_N+1];
  lav_ctl_t lz_ctl_r [LZ_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) lz_ctl_r[0] <= '0;
    else if (en) lz_ctl_r[0] <= in_ctl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz_a_r[0] <= mag_c;
      lz_m_r[0] <= m_c;
      lz_sd_r[0] <= {in_sb, m_c == '0, sg_c};
    end
  end

  // left-justify the largest magnitude, one shift step per stage
  for (genvar k = 0; k < LZ_N; k++) begin : g_lz
    localparam int SH = 32 >> k;
    always_ff @(posedge clk) begin
      if (!rst_n) lz_ctl_r[k+1] <= '0;
      else if (en) lz_ctl_r[k+1] <= lz_ctl_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lz_sd_r[k+1] <= lz_sd_r[k];
        if (lz_m_r[k][IN_W-1 -: SH] == '0) begin
          lz_m_r[k+1] <= lz_m_r[k] << SH;
          for (int i = 0; i < 3; i++) lz_a_r[k+1][i] <= lz_a_r[k][i] << SH;
        end else begin
          lz_m_r[k+1] <= lz_m_r[k];
          lz_a_r[k+1] <= lz_a_r[k];
        end
      end
    end
  end

  // squares of the aligned magnitudes
  logic [2:0][NORM_W-1:0] sq_a_r;
  logic [2:0][2*NORM_W-1:0] sq_r;
  logic [SD_W-1:0] sq_sd_r;
  lav_ctl_t sq_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sq_ctl_r <= '0;
    else if (en) sq_ctl_r <= lz_ctl_r[LZ_N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sd_r <= lz_sd_r[LZ_N];
      for (int i = 0; i < 3; i++) begin
        sq_a_r[i] <= lz_a_r[LZ_N][i][IN_W-1 -: NORM_W];
        sq_r[i] <= lz_a_r[LZ_N][i][IN_W-1 -: NORM_W] * lz_a_r[LZ_N][i][IN_W-1 -: NORM_W];
      end
    end
  end

  // integer square root, one result bit per stage
  logic [SUM_W-1:0] sr_n_r [ROOT_STEPS+1];
  logic [SUM_W-1:0] sr_res_r [ROOT_STEPS+1];
  logic [2:0][NORM_W-1:0] sr_a_r [ROOT_STEPS+1];
  logic [SD_W-1:0] sr_sd_r [ROOT_STEPS+1];
  lav_ctl_t sr_ctl_r [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sr_ctl_r[0] <= '0;
    else if (en) sr_ctl_r[0] <= sq_ctl_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_n_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      sr_res_r[0] <= '0;
      sr_a_r[0] <= sq_a_r;
      sr_sd_r[0] <= sq_sd_r;
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [SUM_W-1:0] trial;
    assign trial = sr_res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) sr_ctl_r[k+1] <= '0;
      else if (en) sr_ctl_r[k+1] <= sr_ctl_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr_a_r[k+1] <= sr_a_r[k];
        sr_sd_r[k+1] <= sr_sd_r[k];
        if (sr_n_r[k] >= trial) begin
          sr_n_r[k+1] <= sr_n_r[k] - trial;
          sr_res_r[k+1] <= (sr_res_r[k] >> 1) + BIT;
        end else begin
          sr_n_r[k+1] <= sr_n_r[k];
          sr_res_r[k+1] <= sr_res_r[k] >> 1;
        end
      end
    end
  end

  // restoring division mag * 2^16 / len, one quotient bit per stage
  logic [2:0][REM_W-1:0] dv_rem_r [DV_N+1];
  logic [2:0][QUO_W-1:0] dv_q_r [DV_N+1];
  logic [LEN_W-1:0] dv_len_r [DV_N+1];
  logic [SD_W-1:0] dv_sd_r [DV_N+1];
  lav_ctl_t dv_ctl_r [DV_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_ctl_r[0] <= '0;
    else if (en) dv_ctl_r[0] <= sr_ctl_r[ROOT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dv_rem_r[0][i] <= REM_W'(sr_a_r[ROOT_STEPS][i]);
      dv_q_r[0] <= '0;
      dv_len_r[0] <= sr_res_r[ROOT_STEPS][LEN_W-1:0];
      dv_sd_r[0] <= sr_sd_r[ROOT_STEPS];
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_div
    logic [2:0][REM_W-1:0] t;
    logic [2:0] ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = (k == 0) ? dv_rem_r[k][i] : (dv_rem_r[k][i] << 1);
        ge[i] = t[i] >= REM_W'(dv_len_r[k]);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_ctl_r[k+1] <= '0;
      else if (en) dv_ctl_r[k+1] <= dv_ctl_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len_r[k+1] <= dv_len_r[k];
        dv_sd_r[k+1] <= dv_sd_r[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k+1][i] <= ge[i] ? (t[i] - REM_W'(dv_len_r[k])) : t[i];
          dv_q_r[k+1][i] <= {dv_q_r[k][i][QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  // sign back on, zero axis on zero length
  logic [2:0][AXIS_W-1:0] o_c;
  logic zero_c;

  always_comb begin
    zero_c = dv_sd_r[DV_N][3];
    for (int i = 0; i < 3; i++) begin
      o_c[i] = AXIS_W'(dv_q_r[DV_N][i]);
      if (zero_c) o_c[i] = '0;
      else if (dv_sd_r[DV_N][i]) o_c[i] = -o_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_ctl <= '0;
    else if (en) begin
      out_ctl.vld <= dv_ctl_r[DV_N].vld;
      out_ctl.degen <= dv_ctl_r[DV_N].degen | zero_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_o <= o_c;
      out_sb <= dv_sd_r[DV_N][SD_W-1:4];
    end
  end

endmodule

### sv/lav_cross.sv
module lav_cross #(
  parameter int A_W = 18,
  parameter int B_W = 32,
  parameter int SB_W = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  lav_pkg::lav_ctl_t in_ctl,
  input  logic [2:0][A_W-1:0] in_a,
  input  logic [2:0][B_W-1:0] in_b,
  input  logic [SB_W-1:0] in_sb,
  output lav_pkg::lav_ctl_t out_ctl,
  output logic [2:0][A_W+B_W:0] out_o,
  output logic [SB_W-1:0] out_sb
);
  import lav_pkg::*;

  localparam int P_W = A_W + B_W;
  localparam int O_W = P_W + 1;

  logic signed [P_W-1:0] p_r [6];
  logic [SB_W-1:0] sb_r;
  lav_ctl_t ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
      out_ctl <= ctl_r;
    end
  end

  // products first, differences one stage later
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= $signed(in_a[1]) * $signed(in_b[2]);
      p_r[1] <= $signed(in_a[2]) * $signed(in_b[1]);
      p_r[2] <= $signed(in_a[2]) * $signed(in_b[0]);
      p_r[3] <= $signed(in_a[0]) * $signed(in_b[2]);
      p_r[4] <= $signed(in_a[0]) * $signed(in_b[1]);
      p_r[5] <= $signed(in_a[1]) * $signed(in_b[0]);
      sb_r <= in_sb;
      out_o[0] <= O_W'(p_r[0]) - O_W'(p_r[1]);
      out_o[1] <= O_W'(p_r[2]) - O_W'(p_r[3]);
      out_o[2] <= O_W'(p_r[4]) - O_W'(p_r[5]);
      out_sb <= sb_r;
    end
  end

endmodule

### sv/lav_serial.sv
module lav_serial #(
  parameter int DATA_WIDTH = lav_pkg::DATA_WIDTH_DEF,
  localparam int OUT_TW = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic ld,
  input  lav_pkg::lav_rows_t rows,
  output logic free,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [OUT_TW-1:0] out_tdata,
  output logic out_tlast,
  output logic [2:0] out_tuser
);
  import lav_pkg::*;

  localparam int CW = (DATA_WIDTH > CORE_W) ? CORE_W : DATA_WIDTH;
  localparam logic [CORE_W-1:0] ROW3_T = (CW > FRAC + 1) ? CORE_W'(1 << FRAC)
                                        : CORE_W'((64'd1 << (CW - 1)) - 64'd1);

  logic busy_r, busy_nxt;
  logic [1:0] row_r, row_nxt;
  lav_rows_t rows_r;
  logic [3:0][CORE_W-1:0] col_c;

  assign free = !busy_r || (out_tready && row_r == ROW_LAST);

  always_comb begin
    busy_nxt = busy_r;
    row_nxt = row_r;
    if (ld) begin
      busy_nxt = 1'b1;
      row_nxt = ROW_RIGHT;
    end else if (busy_r && out_tready) begin
      if (row_r == ROW_LAST) busy_nxt = 1'b0;
      else row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r <= ROW_RIGHT;
    end else begin
      busy_r <= busy_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) rows_r <= rows;
  end

  always_comb begin
    case (row_r)
      ROW_RIGHT: col_c = {rows_r.tr[0], rows_r.ax[0]};
      ROW_UP:    col_c = {rows_r.tr[1], rows_r.ax[1]};
      ROW_FWD:   col_c = {rows_r.tr[2], rows_r.ax[2]};
      default:   col_c = {ROW3_T, {3{CORE_W'(0)}}};
    endcase
  end

  always_comb begin
    out_tdata = '0;
    for (int j = 0; j < 4; j++) out_tdata[j*DATA_WIDTH +: DATA_WIDTH] = DATA_WIDTH'(col_c[j][CW-1:0]);
  end

  assign out_tvalid = busy_r;
  assign out_tlast = row_r == ROW_LAST;
  assign out_tuser = {rows_r.degen, row_r};

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ld |=> busy_r && row_r == ROW_RIGHT)
    else $error("row sequence did not restart on load");

  a_hold_row: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_tready && !ld |=> busy_r && $stable(row_r))
    else $error("row changed while stalled");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_tready && row_r != ROW_LAST && !ld |=> row_r == $past(row_r) + 2'd1)
    else $error("row skipped");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> free)
    else $error("new rows loaded over undelivered rows");

endmodule

### sv/look_at_view_matrix.sv
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: cam_x,y,z, target_x,y,z, up_x,y,z
// out_    | out | out_tvalid/tready   | tdata: col0..col3; tlast: last_row;
//         |     |                     | tuser: row_index, degenerate
//
// each set-up puts out four rows; new set-ups enter while rows are still sent
// path from input acceptance until the first row is offered:
// two normalizers (32-step root, 17-step divide, 60 stages each), two cross
// products, dot products and saturation
// the whole pipeline advances together; it holds while the row buffer still
// has rows and a finished item waits at the tail, so nothing is lost
// synchronous active-low reset clears valid bits, row buffer busy and row index only
module look_at_view_matrix #(
  parameter int DATA_WIDTH = lav_pkg::DATA_WIDTH_DEF,
  localparam int IN_TW = ((9 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // cam_x, cam_y, cam_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [IN_TW-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // col0, col1, col2, col3
  output logic [OUT_TW-1:0] out_tdata,
  output logic out_tlast,
  // row_index [1:0], degenerate [2]
  output logic [2:0] out_tuser
);
  import lav_pkg::*;

  localparam int CW = (DATA_WIDTH > CORE_W) ? CORE_W : DATA_WIDTH;
  localparam int D_W = CORE_W + 1;
  localparam int V_W = 3 * CORE_W;
  localparam int A3_W = 3 * AXIS_W;
  localparam int C1_W = AXIS_W + CORE_W + 1;
  localparam int C2_W = 2 * AXIS_W + 1;
  localparam int P_W = UY_W + CORE_W;
  localparam int DT_W = P_W + 2;
  localparam int ND_W = DT_W + 1;
  localparam logic signed [ND_W-1:0] SAT_HI = ND_W'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [ND_W-1:0] SAT_LO = -SAT_HI - ND_W'(1);

  logic adv, ser_free, ld;

  // ---- stage 0: unpack fields, camera minus target
  logic [2:0][CORE_W-1:0] cam_c, tgt_c, up_c;
  logic [2:0][D_W-1:0] d_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_c[i] = CORE_W'(signed'(in_tdata[i*DATA_WIDTH +: CW]));
      tgt_c[i] = CORE_W'(signed'(in_tdata[(3+i)*DATA_WIDTH +: CW]));
      up_c[i] = CORE_W'(signed'(in_tdata[(6+i)*DATA_WIDTH +: CW]));
      d_c[i] = D_W'(signed'(cam_c[i])) - D_W'(signed'(tgt_c[i]));
    end
  end

  logic [2:0][D_W-1:0] d_r;
  logic [2:0][CORE_W-1:0] cam0_r, up0_r;
  lav_ctl_t ctl0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ctl0_r <= '0;
    else if (adv) ctl0_r <= '{vld: in_tvalid, degen: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_c;
      cam0_r <= cam_c;
      up0_r <= up_c;
    end
  end

  // ---- forward axis
  lav_ctl_t n1_ctl;
  logic [2:0][AXIS_W-1:0] fz1;
  logic [2*V_W-1:0] n1_sb;
  logic [2:0][CORE_W-1:0] up1;

  lav_norm #(.IN_W(D_W), .SB_W(2 * V_W)) u_norm_f (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_ctl(ctl0_r), .in_v(d_r), .in_sb({cam0_r, up0_r}),
    .out_ctl(n1_ctl), .out_o(fz1), .out_sb(n1_sb)
  );

  assign up1 = n1_sb[V_W-1:0];

  // ---- forward cross up
  lav_ctl_t c1_ctl;
  logic [2:0][C1_W-1:0] c1;
  logic [A3_W+V_W-1:0] c1_sb;

  lav_cross #(.A_W(AXIS_W), .B_W(CORE_W), .SB_W(A3_W + V_W)) u_cross_r (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_ctl(n1_ctl), .in_a(fz1), .in_b(up1), .in_sb({fz1, n1_sb[2*V_W-1:V_W]}),
    .out_ctl(c1_ctl), .out_o(c1), .out_sb(c1_sb)
  );

  // ---- right axis
  lav_ctl_t n2_ctl;
  logic [2:0][AXIS_W-1:0] rx2, fz2;
  logic [A3_W+V_W-1:0] n2_sb;

  lav_norm #(.IN_W(C1_W), .SB_W(A3_W + V_W)) u_norm_r (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_ctl(c1_ctl), .in_v(c1), .in_sb(c1_sb),
    .out_ctl(n2_ctl), .out_o(rx2), .out_sb(n2_sb)
  );

  assign fz2 = n2_sb[A3_W+V_W-1:V_W];

  // ---- right cross forward gives true up
  lav_ctl_t c2_ctl;
  logic [2:0][C2_W-1:0] c2;
  logic [2*A3_W+V_W-1:0] c2_sb;

  lav_cross #(.A_W(AXIS_W), .B_W(AXIS_W), .SB_W(2 * A3_W + V_W)) u_cross_u (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_ctl(n2_ctl), .in_a(rx2), .in_b(fz2), .in_sb({rx2, n2_sb}),
    .out_ctl(c2_ctl), .out_o(c2), .out_sb(c2_sb)
  );

  logic [2:0][AXIS_W-1:0] rx3, fz3;
  logic [2:0][CORE_W-1:0] cam3;

  assign rx3 = c2_sb[2*A3_W+V_W-1:A3_W+V_W];
  assign fz3 = c2_sb[A3_W+V_W-1:V_W];
  assign cam3 = c2_sb[V_W-1:0];

  // ---- stage t1: axes side by side, up floored by 2^16
  logic [2:0][2:0][UY_W-1:0] ax1_r;
  logic [2:0][CORE_W-1:0] cam1_r;
  lav_ctl_t ctl1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ax1_r[ROW_RIGHT][i] <= UY_W'(signed'(rx3[i]));
        ax1_r[ROW_UP][i] <= UY_W'($signed(c2[i]) >>> FRAC);
        ax1_r[ROW_FWD][i] <= UY_W'(signed'(fz3[i]));
      end
      cam1_r <= cam3;
    end
  end

  // ---- stage t2: axis times camera
  logic signed [P_W-1:0] p2_r [3][3];
  logic [2:0][2:0][UY_W-1:0] ax2_r;
  lav_ctl_t ctl2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) p2_r[r][i] <= $signed(ax1_r[r][i]) * $signed(cam1_r[i]);
      end
      ax2_r <= ax1_r;
    end
  end

  // ---- stage t3: dot products
  logic signed [DT_W-1:0] dot3_r [3];
  logic [2:0][2:0][UY_W-1:0] ax3_r;
  lav_ctl_t ctl3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        dot3_r[r] <= DT_W'(p2_r[r][0]) + DT_W'(p2_r[r][1]) + DT_W'(p2_r[r][2]);
      end
      ax3_r <= ax2_r;
    end
  end

  // ---- stage t4: negate, floor shift, saturate
  lav_rows_t rows_c, rows4_r;
  lav_ctl_t ctl4_r;
  logic signed [ND_W-1:0] sh_c [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh_c[r] = (-ND_W'(dot3_r[r])) >>> FRAC;
      if (sh_c[r] > SAT_HI) rows_c.tr[r] = CORE_W'(SAT_HI);
      else if (sh_c[r] < SAT_LO) rows_c.tr[r] = CORE_W'(SAT_LO);
      else rows_c.tr[r] = CORE_W'(sh_c[r]);
      for (int i = 0; i < 3; i++) rows_c.ax[r][i] = CORE_W'(signed'(ax3_r[r][i]));
    end
    rows_c.degen = ctl3_r.degen;
  end

  always_ff @(posedge clk) begin
    if (adv) rows4_r <= rows_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (adv) begin
      ctl1_r <= c2_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // pipeline moves unless a finished item waits on a busy row buffer
  assign adv = !ctl4_r.vld || ser_free;
  assign ld = ctl4_r.vld && ser_free;
  assign in_tready = adv;

  lav_serial #(.DATA_WIDTH(DATA_WIDTH)) u_serial (
    .clk(clk), .rst_n(rst_n), .ld(ld), .rows(rows4_r), .free(ser_free),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

endmodule

### sim/tb_look_at_view_matrix.sv
module tb_look_at_view_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  import lav_pkg::*;

  localparam int DW = 32;
  localparam int IN_TW = ((9 * DW + 7) / 8) * 8;
  localparam int OUT_TW = ((4 * DW + 7) / 8) * 8;
  localparam int N_RANDOM = 150;
  // random items in each of the two idling phases, the rest go to the last
  localparam int N_EARLY = 5;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  // degenerate flag as typed in the table: unknown, clear, set
  typedef enum logic [1:0] {DG_ANY, DG_NO, DG_YES} degen_hint_t;

  // one camera set-up: cam, target, up, each x,y,z
  typedef struct {
    logic signed [31:0] v [9];
    degen_hint_t hint;
  } setup_t;

  typedef struct packed {
    logic [1:0] row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic last;
    logic degen;
  } view_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic out_tlast;
  logic [2:0] out_tuser;

  // rows still owed by the block, oldest first
  view_row_t rows_due[$];
  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_req;

  look_at_view_matrix #(.DATA_WIDTH(DW)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magn(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // unit vector in Q16.16, truncated toward zero; returns 1 on zero length
  function automatic bit to_unit(input longint v [3], output longint o [3]);
    longint unsigned a [3];
    longint unsigned m;
    longint unsigned len;
    longint q;
    a[0] = magn(v[0]);
    a[1] = magn(v[1]);
    a[2] = magn(v[2]);
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m == 0) begin
      o[0] = 0;
      o[1] = 0;
      o[2] = 0;
      return 1'b1;
    end
    // align so the largest magnitude lies in [2^30, 2^31)
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    len = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    for (int i = 0; i < 3; i++) begin
      q = longint'((a[i] << FRAC) / len);
      o[i] = (v[i] < 0) ? -q : q;
    end
    return 1'b0;
  endfunction

  function automatic void cross_prod(input longint a [3], input longint b [3],
                                     output longint o [3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(S_MAX)) return longint'(S_MAX);
    if (v < longint'(S_MIN)) return longint'(S_MIN);
    return v;
  endfunction

  // expected four rows of the view matrix for one set-up
  task automatic predict_view(input setup_t s);
    longint cam [3];
    longint tgt [3];
    longint upv [3];
    longint dv [3];
    longint fwd [3];
    longint rgt [3];
    longint tup [3];
    longint tmp [3];
    longint ax [3];
    longint dot;
    bit degen;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      cam[i] = longint'(s.v[i]);
      tgt[i] = longint'(s.v[3 + i]);
      upv[i] = longint'(s.v[6 + i]);
      dv[i] = cam[i] - tgt[i];
    end
    degen = to_unit(dv, fwd);
    cross_prod(fwd, upv, tmp);
    if (to_unit(tmp, rgt)) degen = 1'b1;
    cross_prod(rgt, fwd, tmp);
    // arithmetic shift rounds toward minus infinity
    for (int i = 0; i < 3; i++) tup[i] = tmp[i] >>> FRAC;
    if (s.hint == DG_NO) degen = 1'b0;
    if (s.hint == DG_YES) degen = 1'b1;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++)
        ax[i] = (k == 0) ? rgt[i] : (k == 1) ? tup[i] : fwd[i];
      dot = ax[0] * cam[0] + ax[1] * cam[1] + ax[2] * cam[2];
      r.row = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_FWD;
      r.c0 = ax[0][31:0];
      r.c1 = ax[1][31:0];
      r.c2 = ax[2][31:0];
      r.c3 = 32'(clamp32((-dot) >>> FRAC));
      r.last = 1'b0;
      r.degen = degen;
      rows_due.push_back(r);
    end
    r.row = ROW_LAST;
    r.c0 = '0;
    r.c1 = '0;
    r.c2 = '0;
    r.c3 = Q_ONE;
    r.last = 1'b1;
    r.degen = degen;
    rows_due.push_back(r);
  endtask

  // offer one set-up, wait for the handshake, then book its rows
  task automatic send_setup(input setup_t s);
    logic [IN_TW-1:0] word;
    word = '0;
    for (int i = 0; i < 9; i++) word[i*32 +: 32] = s.v[i];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    predict_view(s);
  endtask

  function automatic logic signed [31:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    if (sel < 80) return $signed($urandom);
    if (sel < 90) return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
    return $urandom_range(1) ? S_MAX : S_MIN;
  endfunction

  function automatic setup_t rand_setup();
    setup_t s;
    int kind;
    s.hint = DG_ANY;
    for (int i = 0; i < 9; i++) s.v[i] = rand_coord();
    kind = $urandom_range(99);
    // occasional camera on the target
    if (kind < 5) begin
      for (int i = 0; i < 3; i++) s.v[3 + i] = s.v[i];
    // occasional up hint along the view direction
    end else if (kind < 10) begin
      for (int i = 0; i < 3; i++) s.v[6 + i] = (s.v[i] - s.v[3 + i]) >>> 4;
    end
    return s;
  endfunction

  function automatic setup_t mk(input int cx, cy, cz, tx, ty, tz, ux, uy, uz,
                                input degen_hint_t h);
    setup_t s;
    s.v[0] = cx; s.v[1] = cy; s.v[2] = cz;
    s.v[3] = tx; s.v[4] = ty; s.v[5] = tz;
    s.v[6] = ux; s.v[7] = uy; s.v[8] = uz;
    s.hint = h;
    return s;
  endfunction

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    view_row_t want;
    view_row_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.row = out_tuser[1:0];
      got.c0 = out_tdata[31:0];
      got.c1 = out_tdata[63:32];
      got.c2 = out_tdata[95:64];
      got.c3 = out_tdata[127:96];
      got.last = out_tlast;
      got.degen = out_tuser[2];
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %h", got);
      end else begin
        want = rows_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("row mismatch: exp row=%0d %h %h %h %h last=%b dg=%b",
                     want.row, want.c0, want.c1, want.c2, want.c3, want.last,
                     want.degen);
            $display("              got row=%0d %h %h %h %h last=%b dg=%b",
                     got.row, got.c0, got.c1, got.c2, got.c3, got.last, got.degen);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    setup_t dir_tab [$];
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all zero: forward axis has no length
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, DG_YES));
    // camera on the target with a proper up hint
    dir_tab.push_back(mk(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
                         0, Q_ONE, 0, DG_YES));
    // up hint parallel to the view direction
    dir_tab.push_back(mk(0, 5 * Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0, DG_YES));
    // zero up hint
    dir_tab.push_back(mk(0, 0, 5 * Q_ONE, 0, 0, 0, 0, 0, 0, DG_YES));
    // textbook cases
    dir_tab.push_back(mk(0, 0, 5 * Q_ONE, 0, 0, 0, 0, Q_ONE, 0, DG_NO));
    dir_tab.push_back(mk(3 * Q_ONE, 4 * Q_ONE, -5 * Q_ONE, 0, 0, 0, 0, Q_ONE, 0, DG_NO));
    dir_tab.push_back(mk(-7, 13, -1, 5, -9, 2, 1, 1, -1, DG_NO));
    dir_tab.push_back(mk(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, -Q_ONE, DG_NO));
    // field extremes, translation saturates both ways
    dir_tab.push_back(mk(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 0, Q_ONE, 0, DG_ANY));
    dir_tab.push_back(mk(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX,
                         DG_ANY));
    dir_tab.push_back(mk(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX,
                         DG_ANY));
    dir_tab.push_back(mk(S_MIN, 0, 0, 0, 0, 0, 0, S_MAX, 0, DG_NO));
    dir_tab.push_back(mk(S_MAX, 0, S_MAX, 0, S_MIN, 0, S_MIN, S_MIN, S_MIN, DG_ANY));
    dir_tab.push_back(mk(-1, -1, -1, 0, 0, 0, -1, 0, 0, DG_NO));
    dir_tab.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0, DG_NO));
    dir_tab.push_back(mk(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh3333_3333, 32'shcccc_cccc,
                         32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh00ff_00ff, 32'shff00_ff00,
                         32'sh1234_5678, DG_ANY));

    // receiver idles more first, then the sender, then neither
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 30 : 0;
      if (phase == 0) begin
        foreach (dir_tab[i]) send_setup(dir_tab[i]);
      end
      if (phase == 2) begin
        // long receiver hold-off while items keep coming, block backs up
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      // enough items in the last phase to fill the whole pipeline
      n = (phase == 2) ? N_RANDOM - 2 * N_EARLY : N_EARLY;
      for (int i = 0; i < n; i++) send_setup(rand_setup());
      in_tvalid <= 1'b0;
      // sender pauses until the block has drained
      while (rows_due.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lav_pkg.sv
sv/lav_norm.sv
sv/lav_cross.sv
sv/lav_serial.sv
sv/look_at_view_matrix.sv
sim/tb_look_at_view_matrix.sv
